FILE: hdl/dtab_pkg.sv
// Shared item types for the depth-tested alpha blend core.
package dtab_pkg;

    localparam int unsigned FULL_BRIGHT = 32767;
    localparam int unsigned OPAQUE      = 255;

    typedef struct packed {
        logic [7:0]  dest_red;
        logic [7:0]  dest_green;
        logic [7:0]  dest_blue;
        logic [31:0] stored_depth;
        logic [7:0]  src_red;
        logic [7:0]  src_green;
        logic [7:0]  src_blue;
        logic [7:0]  src_alpha;
        logic [31:0] new_depth;
        logic [14:0] brightness;
    } t_pixel_in;

    typedef struct packed {
        logic        written;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [31:0] out_depth;
    } t_pixel_out;

endpackage

FILE: hdl/depth_tested_alpha_blend_core.sv
// Depth-tested alpha blend core: four-stage pixel pipeline.
//
// Usage: drive one pixel item on i_item and raise start; the item is taken at
// each rising edge where start is high and busy is low. busy is high only
// during reset and the cycle after it, so a pixel may enter every clock.
// Each item yields one result on o_result, marked by o_strobe for exactly one
// cycle (throughput 1 item/cycle).
// The stages are: depth test and the two small products, the texel-times-
// alpha-times-brightness product, the exact divide by 32767 with the
// destination term added, and the exact divide by 255 into the output
// register. The receiver cannot stall; results are never held.
// The ignore_depth register is written over the cfg channel (i_cfg_valid,
// o_cfg_ready, i_cfg_data); o_cfg_ready is the inverse of busy. Write it only
// while no item is in flight. Reset clears the register and all valid bits.
// DEPTH_BITS sets how many low bits of the depths take part in the test.
module depth_tested_alpha_blend_core
    import dtab_pkg::*;
#(
    parameter int unsigned DEPTH_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_pixel_in  i_item,
    output logic       o_strobe,
    output t_pixel_out o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    localparam logic [31:0] DEPTH_MASK = (DEPTH_BITS >= 32) ? 32'hFFFF_FFFF
                                         : ((32'd1 << DEPTH_BITS) - 32'd1);

    function automatic logic [15:0] div_32767(input logic [30:0] x);
        logic [16:0] r;
        logic [15:0] r1;
        logic [16:0] q;
        r  = {2'b00, x[14:0]} + {1'b0, x[30:15]};
        r1 = {1'b0, r[14:0]} + {14'd0, r[16:15]};
        q  = {1'b0, x[30:15]} + {15'd0, r[16:15]}
             + {16'd0, (r1 >= 16'(FULL_BRIGHT))};
        return q[15:0];
    endfunction

    function automatic logic [7:0] div_255(input logic [16:0] y);
        logic [9:0] r;
        logic [8:0] r1;
        logic [9:0] q;
        r  = {2'b00, y[7:0]} + {1'b0, y[16:8]};
        r1 = {1'b0, r[7:0]} + {7'd0, r[9:8]};
        q  = {1'b0, y[16:8]} + {8'd0, r[9:8]} + {9'd0, (r1 >= 9'(OPAQUE))};
        return q[7:0];
    endfunction

    logic        r_run;
    logic        r_ignore_depth;
    logic        w_accept;

    logic        r1_valid, r2_valid, r3_valid, r_strobe;
    logic        r1_pass, r2_pass, r3_pass;
    logic [7:0]  r1_dest [3];
    logic [7:0]  r2_dest [3];
    logic [7:0]  r3_dest [3];
    logic [7:0]  r1_src  [3];
    logic [15:0] r1_dinv [3];
    logic [15:0] r2_dinv [3];
    logic [22:0] r1_ab;
    logic [30:0] r2_p    [3];
    logic [16:0] r3_sum  [3];
    logic [31:0] r1_depth, r2_depth, r3_depth;
    t_pixel_out  r_result;

    logic [7:0]  n_dest [3];
    logic [7:0]  n_src  [3];
    logic [7:0]  n_inv;
    logic        n_pass;
    logic [7:0]  n_blend [3];

    assign busy        = ~r_run;
    assign o_cfg_ready = r_run;
    assign w_accept    = start & ~busy;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    always_comb begin
        n_dest[0] = i_item.dest_red;
        n_dest[1] = i_item.dest_green;
        n_dest[2] = i_item.dest_blue;
        n_src[0]  = i_item.src_red;
        n_src[1]  = i_item.src_green;
        n_src[2]  = i_item.src_blue;
        n_inv     = 8'(OPAQUE) - i_item.src_alpha;
        n_pass    = (i_item.brightness != 15'd0) && (i_item.src_alpha != 8'd0)
                    && ((i_item.stored_depth & DEPTH_MASK)
                        > (i_item.new_depth & DEPTH_MASK));
        for (int c = 0; c < 3; c++) begin
            n_blend[c] = div_255(r3_sum[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run          <= 1'b0;
            r_ignore_depth <= 1'b0;
            r1_valid       <= 1'b0;
            r2_valid       <= 1'b0;
            r3_valid       <= 1'b0;
            r_strobe       <= 1'b0;
        end else begin
            r_run    <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ignore_depth <= i_cfg_data;
            end
            r1_valid <= w_accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r_strobe <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: depth test, a*b and d*(255-a)
        r1_pass  <= n_pass;
        r1_ab    <= {15'd0, i_item.src_alpha} * {8'd0, i_item.brightness};
        r1_depth <= (n_pass && !r_ignore_depth) ? (i_item.new_depth & DEPTH_MASK)
                                                : i_item.stored_depth;
        for (int c = 0; c < 3; c++) begin
            r1_dest[c] <= n_dest[c];
            r1_src[c]  <= n_src[c];
            r1_dinv[c] <= {8'd0, n_dest[c]} * {8'd0, n_inv};
        end
        // stage 2: s*a*b
        r2_pass  <= r1_pass;
        r2_depth <= r1_depth;
        for (int c = 0; c < 3; c++) begin
            r2_dest[c] <= r1_dest[c];
            r2_dinv[c] <= r1_dinv[c];
            r2_p[c]    <= {23'd0, r1_src[c]} * {8'd0, r1_ab};
        end
        // stage 3: divide by 32767, add destination term
        r3_pass  <= r2_pass;
        r3_depth <= r2_depth;
        for (int c = 0; c < 3; c++) begin
            r3_dest[c] <= r2_dest[c];
            r3_sum[c]  <= {1'b0, r2_dinv[c]} + {1'b0, div_32767(r2_p[c])};
        end
        // stage 4: divide by 255, select
        r_result.written   <= r3_pass;
        r_result.out_red   <= r3_pass ? n_blend[0] : r3_dest[0];
        r_result.out_green <= r3_pass ? n_blend[1] : r3_dest[1];
        r_result.out_blue  <= r3_pass ? n_blend[2] : r3_dest[2];
        r_result.out_depth <= r3_depth;
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_strobe)
        else $error("accepted item did not emerge after four cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, 4))
        else $error("result strobe without a matching item");

    a_reject_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.written)
            |-> o_result.out_depth == $past(i_item.stored_depth, 4))
        else $error("rejected pixel changed the stored depth");

    a_pass_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.written)
            |-> ($past(i_item.brightness, 4) != 15'd0)
                && ($past(i_item.src_alpha, 4) != 8'd0))
        else $error("pixel written with zero alpha or brightness");

endmodule

FILE: tb/depth_tested_alpha_blend_checker.sv
// Checker for the depth-tested alpha blend core: predicts each pixel result and compares it.
`timescale 1ns / 1ps

module depth_tested_alpha_blend_checker
    import dtab_pkg::*;
#(
    parameter int unsigned DEPTH_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  t_pixel_in  i_item,
    input  logic       i_strobe,
    input  t_pixel_out i_result,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam logic [63:0] DEPTH_MASK =
        (DEPTH_BITS >= 64) ? '1 : ((64'd1 << DEPTH_BITS) - 64'd1);

    t_pixel_out expected_pixels[$];
    logic       ignore_depth_q;
    int         mismatches = 0;

    function automatic logic [7:0] blend_channel(logic [7:0] d, logic [7:0] s,
                                                 logic [7:0] a, logic [14:0] br);
        longint unsigned dv, sv, av, bv, inv, lit;
        dv  = d;
        sv  = s;
        av  = a;
        bv  = br;
        inv = OPAQUE - av;
        if (bv == FULL_BRIGHT) begin
            if (av == OPAQUE) return s;
            return 8'((dv * inv + sv * av) / OPAQUE);
        end
        if (av == OPAQUE) return 8'((sv * bv) / FULL_BRIGHT);
        lit = (sv * (av * bv)) / FULL_BRIGHT;
        return 8'((dv * inv + lit) / OPAQUE);
    endfunction

    function automatic t_pixel_out predict_pixel(t_pixel_in p, logic ignore_depth);
        t_pixel_out r;
        logic       passes;
        passes = (p.brightness != 0) && (p.src_alpha != 0) &&
                 ((64'(p.stored_depth) & DEPTH_MASK) > (64'(p.new_depth) & DEPTH_MASK));
        if (!passes) begin
            r.written   = 1'b0;
            r.out_red   = p.dest_red;
            r.out_green = p.dest_green;
            r.out_blue  = p.dest_blue;
            r.out_depth = p.stored_depth;
        end else begin
            r.written   = 1'b1;
            r.out_red   = blend_channel(p.dest_red, p.src_red, p.src_alpha, p.brightness);
            r.out_green = blend_channel(p.dest_green, p.src_green, p.src_alpha,
                                        p.brightness);
            r.out_blue  = blend_channel(p.dest_blue, p.src_blue, p.src_alpha, p.brightness);
            r.out_depth = ignore_depth ? p.stored_depth
                                       : 32'(64'(p.new_depth) & DEPTH_MASK);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, t_pixel_out exp_px, t_pixel_out act_px);
        if (mismatches < 10) begin
            $display("%0t mismatch (%s): expected w=%0d rgb=%0d,%0d,%0d z=%h",
                     $realtime, what, exp_px.written, exp_px.out_red, exp_px.out_green,
                     exp_px.out_blue, exp_px.out_depth);
            $display("%0t                 actual   w=%0d rgb=%0d,%0d,%0d z=%h",
                     $realtime, act_px.written, act_px.out_red, act_px.out_green,
                     act_px.out_blue, act_px.out_depth);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_pixel_out exp_px;
        if (!i_rst_n) begin
            expected_pixels.delete();
            ignore_depth_q <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                ignore_depth_q <= i_cfg_data;
            end
            if (i_strobe) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("no pixel pending", '0, i_result);
                end else begin
                    exp_px = expected_pixels.pop_front();
                    if (exp_px.written   !== i_result.written   ||
                        exp_px.out_red   !== i_result.out_red   ||
                        exp_px.out_green !== i_result.out_green ||
                        exp_px.out_blue  !== i_result.out_blue  ||
                        exp_px.out_depth !== i_result.out_depth) begin
                        report_mismatch("pixel result", exp_px, i_result);
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_pixels.push_back(predict_pixel(i_item, ignore_depth_q));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_pixels.size();
    end

endmodule

FILE: tb/depth_tested_alpha_blend_core_tb.sv
// Testbench top for the depth-tested alpha blend core: stimulus, timeout and verdict.
`timescale 1ns / 1ps

module depth_tested_alpha_blend_core_tb;
    import dtab_pkg::*;

    localparam int unsigned DEPTH_BITS  = 32;
    localparam int          LATENCY     = 4;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_ITEMS = 450;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_pixel_in  i_item;
    logic       o_strobe;
    t_pixel_out o_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;
    int         fail_count;
    int         pending;

    depth_tested_alpha_blend_core #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    depth_tested_alpha_blend_checker #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_strobe    (o_strobe),
        .i_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_pixel_in make_pixel(
        logic [7:0] dr, logic [7:0] dg, logic [7:0] db, logic [31:0] sz,
        logic [7:0] sr, logic [7:0] sg, logic [7:0] sb, logic [7:0] a,
        logic [31:0] nz, logic [14:0] br);
        t_pixel_in p;
        p.dest_red     = dr;
        p.dest_green   = dg;
        p.dest_blue    = db;
        p.stored_depth = sz;
        p.src_red      = sr;
        p.src_green    = sg;
        p.src_blue     = sb;
        p.src_alpha    = a;
        p.new_depth    = nz;
        p.brightness   = br;
        return p;
    endfunction

    function automatic t_pixel_in random_pixel();
        t_pixel_in   p;
        int          kind;
        logic [31:0] za, zb;
        p    = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), $urandom,
                          8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          $urandom, 15'($urandom_range(32767)));
        kind = $urandom_range(99);
        if (kind < 75) begin
            za = $urandom;
            zb = $urandom;
            p.stored_depth = (za > zb) ? za : zb;
            p.new_depth    = (za > zb) ? zb : za;
            if (p.src_alpha == 0) p.src_alpha = 8'($urandom_range(1, 255));
            if (p.brightness == 0) p.brightness = 15'($urandom_range(1, 32767));
            if ($urandom_range(3) == 0) p.brightness = 15'(FULL_BRIGHT);
            if ($urandom_range(3) == 0) p.src_alpha = 8'(OPAQUE);
        end else if (kind < 80) begin
            p.stored_depth = p.new_depth;
        end else if (kind < 85) begin
            p.src_alpha = '0;
        end else if (kind < 90) begin
            p.brightness = '0;
        end
        return p;
    endfunction

    task automatic send_pixel(t_pixel_in p, int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= p;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_ignore_depth(logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count, int idle_pct);
        int pct;
        pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) pct = ($urandom_range(2) == 0) ? 0 : idle_pct;
            send_pixel(random_pixel(), pct);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_ignore_depth(1'b0);
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 25);
        send_pixel(make_pixel(255, 255, 255, '1, 255, 255, 255, 255, 0, 32767), 25);
        send_pixel(make_pixel(10, 20, 30, 100, 40, 50, 60, 0, 5, 32767), 25);
        send_pixel(make_pixel(1, 2, 3, 32'h8000_0000, 4, 5, 6, 200, 32'h8000_0000, 32767),
                   25);
        send_pixel(make_pixel(7, 8, 9, 5, 90, 91, 92, 255, 6, 32767), 25);
        send_pixel(make_pixel(255, 255, 255, 1000, 0, 0, 0, 1, 999, 32767), 25);
        send_pixel(make_pixel(0, 0, 0, 1000, 255, 255, 255, 254, 0, 32767), 25);
        send_pixel(make_pixel(12, 200, 77, 5000, 250, 3, 129, 128, 4000, 32767), 25);
        send_pixel(make_pixel(0, 0, 0, 50, 255, 255, 255, 255, 10, 1), 25);
        send_pixel(make_pixel(0, 0, 0, 50, 255, 255, 255, 255, 10, 32766), 25);
        send_pixel(make_pixel(33, 144, 250, 70, 200, 17, 99, 100, 69, 16384), 25);
        send_pixel(make_pixel(255, 255, 255, 70, 255, 255, 255, 1, 3, 1), 25);
        send_pixel(make_pixel(80, 90, 100, 1, 10, 20, 30, 255, 0, 32767), 25);
        send_pixel(make_pixel(5, 6, 7, '1, 250, 251, 252, 255, 32'hFFFF_FFFE, 32766), 25);
        send_pixel(make_pixel(0, 0, 0, 32'h8000_0000, 255, 255, 255, 255, 32'h7FFF_FFFF,
                              32767), 25);
        send_pixel(make_pixel(11, 22, 33, 0, 44, 55, 66, 77, 0, 32767), 25);
        send_pixel(make_pixel(11, 22, 33, 0, 44, 55, 66, 255, '1, 32767), 25);
        wait_for_results();

        write_ignore_depth(1'b1);
        run_random(PHASE_ITEMS, 40);
        wait_for_results();

        write_ignore_depth(1'b0);
        run_random(PHASE_ITEMS, 20);
        wait_for_results();

        write_ignore_depth(1'b1);
        run_random(PHASE_ITEMS, 8);
        wait_for_results();

        write_ignore_depth(1'b0);
        run_random(PHASE_ITEMS, 0);
        wait_for_results();

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
